// ===== src/rmrb_pkg.sv =====
// ----------------------------------------------------------------------------
// rmrb_pkg
// Shared types and constants of the run-masked rectangle blit engine.
// ----------------------------------------------------------------------------
package rmrb_pkg;

    // field widths
    localparam int PIX_W      = 32;
    localparam int CODE_W     = 8;
    localparam int IDX_W      = 20;
    localparam int DIM_REG_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int MAX_DIM_DEF = 1024;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BASE  = 3'd4;

    // transfer modes
    localparam logic MODE_BLIT = 1'b0;
    localparam logic MODE_COPY = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [DIM_REG_W-1:0]  rows;
        logic [DIM_REG_W-1:0]  columns;
        logic [DIM_REG_W-1:0]  dst_width;
        logic [IDX_W-1:0]      dst_base;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:      MODE_BLIT,
        rows:      11'd1,
        columns:   11'd1,
        dst_width: 11'd1024,
        dst_base:  20'd0
    };

    typedef struct packed {
        logic [IDX_W-1:0]         dst_index;
        logic [PIX_W-1:0]         dst_pixel;
        logic signed [CODE_W-1:0] dst_code;
        logic                     bad_code;
        logic                     last;
    } result_t;

endpackage

// ===== src/rmrb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rmrb_cfg_regs
// Configuration register file: decodes writes by index, no read-back.
// ----------------------------------------------------------------------------
module rmrb_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rmrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmrb_pkg::CFG_DATA_W-1:0] cfg_data,
    output rmrb_pkg::cfg_t                 cfg
);
    import rmrb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:      cfg_next.mode      = cfg_data[0];
                CFG_ROWS:      cfg_next.rows      = cfg_data[DIM_REG_W-1:0];
                CFG_COLUMNS:   cfg_next.columns   = cfg_data[DIM_REG_W-1:0];
                CFG_DST_WIDTH: cfg_next.dst_width = cfg_data[DIM_REG_W-1:0];
                CFG_DST_BASE:  cfg_next.dst_base  = cfg_data[IDX_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/rmrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmrb_ctrl
// Input register, raster position, run tracking and destination index.
// ----------------------------------------------------------------------------
module rmrb_ctrl #(
    parameter int MAX_DIM = rmrb_pkg::MAX_DIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rmrb_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rmrb_pkg::PIX_W-1:0]      src_pixel,
    input  logic signed [rmrb_pkg::CODE_W-1:0] run_code,
    input  logic                            buf_ready,
    output logic                            push,
    output rmrb_pkg::result_t               result
);
    import rmrb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = CNT_W + DIM_REG_W;

    // input register
    logic                     item_valid_reg;
    logic [PIX_W-1:0]         pixel_reg;
    logic signed [CODE_W-1:0] code_reg;

    // transfer state
    logic [CNT_W-1:0]  row_count_reg, row_count_next;
    logic [CNT_W-1:0]  col_count_reg, col_count_next;
    logic [CODE_W-1:0] run_left_reg, run_left_next;
    logic              run_copies_reg, run_copies_next;
    logic              aborted_reg, aborted_next;

    logic              fire;
    logic              load;
    logic [DIM_W-1:0]  cols_eff;
    logic [DIM_W-1:0]  rows_eff;
    logic              row_end;
    logic              final_item;
    logic [PROD_W-1:0] row_offset;
    logic [IDX_W-1:0]  index;
    logic              has_res;
    logic              res_bad;
    logic              res_zero;

    assign fire     = item_valid_reg && buf_ready;
    assign in_stall = item_valid_reg && !buf_ready;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= src_pixel;
            code_reg  <= run_code;
        end
    end

    // dimensions: zero acts as one, anything above MAX_DIM is clamped
    always_comb
    begin
        if (cfg.columns == '0)
            cols_eff = DIM_W'(1);
        else if (32'(cfg.columns) > 32'(MAX_DIM))
            cols_eff = DIM_W'(MAX_DIM);
        else
            cols_eff = DIM_W'(cfg.columns);

        if (cfg.rows == '0)
            rows_eff = DIM_W'(1);
        else if (32'(cfg.rows) > 32'(MAX_DIM))
            rows_eff = DIM_W'(MAX_DIM);
        else
            rows_eff = DIM_W'(cfg.rows);
    end

    assign row_end    = (DIM_W'(col_count_reg) + DIM_W'(1)) >= cols_eff;
    assign final_item = row_end && ((DIM_W'(row_count_reg) + DIM_W'(1)) >= rows_eff);

    assign row_offset = PROD_W'(row_count_reg) * PROD_W'(cfg.dst_width);
    assign index      = cfg.dst_base + IDX_W'(row_offset) + IDX_W'(col_count_reg);

    always_comb
    begin
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        run_left_next   = run_left_reg;
        run_copies_next = run_copies_reg;
        aborted_next    = aborted_reg;
        has_res         = 1'b0;
        res_bad         = 1'b0;
        res_zero        = 1'b0;

        if (aborted_reg)
        begin
            has_res = 1'b0;
        end
        else if (cfg.mode == MODE_COPY)
        begin
            has_res = 1'b1;
        end
        else if (run_left_reg == '0)
        begin
            if (code_reg == '0)
            begin
                has_res      = 1'b1;
                res_bad      = 1'b1;
                res_zero     = 1'b1;
                aborted_next = 1'b1;
            end
            else if (!code_reg[CODE_W-1])
            begin
                // copy run, this pixel included
                has_res         = 1'b1;
                run_copies_next = 1'b1;
                run_left_next   = $unsigned(code_reg) - CODE_W'(1);
            end
            else
            begin
                // skip run: -code - 1 is the bitwise complement
                run_copies_next = 1'b0;
                run_left_next   = ~$unsigned(code_reg);
            end
        end
        else
        begin
            run_left_next = run_left_reg - CODE_W'(1);
            has_res       = run_copies_reg;
        end

        if (row_end)
        begin
            col_count_next  = '0;
            run_left_next   = '0;
            run_copies_next = 1'b0;
            if (final_item)
            begin
                row_count_next = '0;
                aborted_next   = 1'b0;
            end
            else
            begin
                row_count_next = row_count_reg + CNT_W'(1);
            end
        end
        else
        begin
            col_count_next = col_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            run_left_reg   <= '0;
            run_copies_reg <= 1'b0;
            aborted_reg    <= 1'b0;
        end
        else if (fire)
        begin
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            run_left_reg   <= run_left_next;
            run_copies_reg <= run_copies_next;
            aborted_reg    <= aborted_next;
        end
    end

    assign push             = fire && has_res;
    assign result.dst_index = index;
    assign result.dst_pixel = res_zero ? '0 : pixel_reg;
    assign result.dst_code  = res_zero ? '0 : code_reg;
    assign result.bad_code  = res_bad;
    assign result.last      = final_item;

    a_final_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && final_item |=> !aborted_reg && row_count_reg == '0 && col_count_reg == '0)
        else $error("position or abort flag not cleared after final item");

    a_row_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        fire && row_end |=> run_left_reg == '0 && !run_copies_reg)
        else $error("run state survived a row end");

    a_abort_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg |-> !push)
        else $error("result emitted during an aborted transfer");

endmodule

// ===== src/rmrb_out_buf.sv =====
// ----------------------------------------------------------------------------
// rmrb_out_buf
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module rmrb_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rmrb_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output rmrb_pkg::result_t out_data
);
    import rmrb_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop   = out_valid_reg && !out_stall;
    assign ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in front");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

endmodule

// ===== src/run_masked_rect_blit.sv =====
// ----------------------------------------------------------------------------
// run_masked_rect_blit
// Masked rectangle blit with run-length transparency codes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  -----------------------------------
//  config    in         cfg_write            cfg_index, cfg_data
//  source    in         in_valid / in_stall  src_pixel, run_code
//  dest      out        out_valid/out_stall  dst_index, dst_pixel, dst_code,
//                                            bad_code, last
//
//  One item per cycle sustained while the destination does not stall. An item
//  is held in the input register, where position, run tracking and the index
//  multiply-add are evaluated, and its result, if any, is then registered in
//  the output buffer. The output side holds two results (output plus skid
//  register); the skid entry catches the result already in flight when the
//  destination stalls, and the source is held only once that entry is full.
//  in_stall rises only while both output entries are full and an item waits.
//  Reset clears position, run state, abort flag and all valid flags and loads
//  the default configuration; no clearing pass is needed.
//
// ----------------------------------------------------------------------------
module run_masked_rect_blit #(
    parameter int MAX_DIM = rmrb_pkg::MAX_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_write,
    input  logic [rmrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmrb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // source items
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rmrb_pkg::PIX_W-1:0]         src_pixel,
    input  logic signed [rmrb_pkg::CODE_W-1:0] run_code,
    // destination writes
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rmrb_pkg::IDX_W-1:0]         dst_index,
    output logic [rmrb_pkg::PIX_W-1:0]         dst_pixel,
    output logic signed [rmrb_pkg::CODE_W-1:0] dst_code,
    output logic                               bad_code,
    output logic                               last
);
    import rmrb_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t out_data;
    logic    push;
    logic    buf_ready;

    // configuration registers, written by the user only while the block is idle; the block does not enforce it
    rmrb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register and per-item run/position logic
    rmrb_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_pixel (src_pixel),
        .run_code  (run_code),
        .buf_ready (buf_ready),
        .push      (push),
        .result    (result)
    );

    // result register with skid entry; skipped pixels never enter it
    rmrb_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .ready     (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign dst_index = out_data.dst_index;
    assign dst_pixel = out_data.dst_pixel;
    assign dst_code  = out_data.dst_code;
    assign bad_code  = out_data.bad_code;
    assign last      = out_data.last;

endmodule
